/* src/pprm_pkg.sv */
`timescale 1ns / 1ps

package pprm_pkg;

  localparam int CGA_N     = 16;
  localparam int SCORE_W   = 20;
  localparam int GROUP_N   = 4;

  typedef logic [3:0]                cga_idx_t;
  typedef logic signed [SCORE_W-1:0] score_t;
  typedef logic [1:0]                lvl_t;
  typedef logic [17:0]               sq_t;

  // Item kinds
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  localparam logic [7:0] TRANSPARENT_CODE = 8'hFF;

  // Component levels of the fixed colours: 0, 85, 170 and 255
  localparam lvl_t LVL_0   = 2'd0;
  localparam lvl_t LVL_85  = 2'd1;
  localparam lvl_t LVL_170 = 2'd2;
  localparam lvl_t LVL_255 = 2'd3;

  // Red, green, blue level of each CGA colour
  localparam lvl_t CGA_LVL [CGA_N][3] = '{
    '{LVL_0,   LVL_0,   LVL_0  }, '{LVL_0,   LVL_0,   LVL_170},
    '{LVL_0,   LVL_170, LVL_0  }, '{LVL_0,   LVL_170, LVL_170},
    '{LVL_170, LVL_0,   LVL_0  }, '{LVL_170, LVL_0,   LVL_170},
    '{LVL_170, LVL_85,  LVL_0  }, '{LVL_170, LVL_170, LVL_170},
    '{LVL_85,  LVL_85,  LVL_85 }, '{LVL_85,  LVL_85,  LVL_255},
    '{LVL_85,  LVL_255, LVL_85 }, '{LVL_85,  LVL_255, LVL_255},
    '{LVL_255, LVL_85,  LVL_85 }, '{LVL_255, LVL_85,  LVL_255},
    '{LVL_255, LVL_255, LVL_85 }, '{LVL_255, LVL_255, LVL_255}
  };

  // Sum of the squared components of each CGA colour
  localparam sq_t CGA_SQ [CGA_N] = '{
    18'd0,      18'd28900,  18'd28900,  18'd57800,
    18'd28900,  18'd57800,  18'd36125,  18'd86700,
    18'd21675,  18'd79475,  18'd79475,  18'd137275,
    18'd79475,  18'd137275, 18'd137275, 18'd195075
  };

  typedef struct packed {
    logic     opcode;
    cga_idx_t entry_index;
    cga_idx_t color_index;
    logic     mask_bit;
  } tag_t;

endpackage

/* src/pprm_in_if.sv */
`timescale 1ns / 1ps

interface pprm_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [3:0] entry_index;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [3:0] color_index;
  logic       mask_bit;

  modport source (
    output valid, opcode, entry_index, red, green, blue, color_index, mask_bit,
    input  ready
  );
  modport sink (
    input  valid, opcode, entry_index, red, green, blue, color_index, mask_bit,
    output ready
  );
endinterface

/* src/pprm_out_if.sv */
`timescale 1ns / 1ps

interface pprm_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_code;

  modport source (output valid, pixel_code, input ready);
  modport sink (input valid, pixel_code, output ready);
endinterface

/* src/pprm_dist.sv */
`timescale 1ns / 1ps

// The squared distance to colour k is |x|^2 - 2<x,c_k> + |c_k|^2. The first
// term is common to all colours, so the score drops it; ordering and ties
// are unchanged.
module pprm_dist (
  input  logic [7:0]      red,
  input  logic [7:0]      green,
  input  logic [7:0]      blue,
  output pprm_pkg::score_t score [pprm_pkg::CGA_N]
);
  import pprm_pkg::*;

  logic [14:0] p85  [3];
  logic [15:0] p170 [3];
  logic [15:0] p255 [3];
  logic [7:0]  comp [3];

  function automatic logic [15:0] pick(input lvl_t lvl, input logic [14:0] a85,
                                       input logic [15:0] a170,
                                       input logic [15:0] a255);
    logic [15:0] res;
    case (lvl)
      LVL_0:   res = 16'd0;
      LVL_85:  res = 16'(a85);
      LVL_170: res = a170;
      LVL_255: res = a255;
      default: res = 16'd0;
    endcase
    return res;
  endfunction

  always_comb begin
    comp[0] = red;
    comp[1] = green;
    comp[2] = blue;
    for (int c = 0; c < 3; c++) begin
      p85[c]  = 15'({comp[c], 6'b0}) + 15'({comp[c], 4'b0}) + 15'({comp[c], 2'b0})
              + 15'(comp[c]);
      p170[c] = {p85[c], 1'b0};
      p255[c] = {comp[c], 8'b0} - 16'(comp[c]);
    end
  end

  always_comb begin
    logic [17:0] dot;
    for (int k = 0; k < CGA_N; k++) begin
      dot = 18'(pick(CGA_LVL[k][0], p85[0], p170[0], p255[0]))
          + 18'(pick(CGA_LVL[k][1], p85[1], p170[1], p255[1]))
          + 18'(pick(CGA_LVL[k][2], p85[2], p170[2], p255[2]));
      score[k] = $signed({2'b00, CGA_SQ[k]}) - $signed({1'b0, dot, 1'b0});
    end
  end

endmodule

/* src/pprm_min4.sv */
`timescale 1ns / 1ps

// Picks the lowest of four scores. The inputs come in rising index order, so
// a later one wins only when strictly lower, which keeps the lowest index on
// a tie.
module pprm_min4 (
  input  pprm_pkg::score_t   score [4],
  input  pprm_pkg::cga_idx_t idx   [4],
  output pprm_pkg::score_t   best_score,
  output pprm_pkg::cga_idx_t win_idx
);
  import pprm_pkg::*;

  score_t   lo_score;
  score_t   hi_score;
  cga_idx_t lo_idx;
  cga_idx_t hi_idx;

  always_comb begin
    if (score[1] < score[0]) begin
      lo_score = score[1];
      lo_idx   = idx[1];
    end else begin
      lo_score = score[0];
      lo_idx   = idx[0];
    end
    if (score[3] < score[2]) begin
      hi_score = score[3];
      hi_idx   = idx[3];
    end else begin
      hi_score = score[2];
      hi_idx   = idx[2];
    end
    if (hi_score < lo_score) begin
      best_score = hi_score;
      win_idx    = hi_idx;
    end else begin
      best_score = lo_score;
      win_idx    = lo_idx;
    end
  end

endmodule

/* src/icon_pixel_palette_remap_unit.sv */
`timescale 1ns / 1ps

// Icon palette remapper with two valid/ready channels.
// in_ch carries either a palette load (opcode 0: entry_index, red, green,
// blue) or a pixel (opcode 1: color_index, mask_bit). out_ch returns one
// pixel_code per item, in order: for a load the nearest CGA colour index,
// which is also written to the remap table; for a pixel 255 when masked,
// otherwise the remap table entry for its palette index.
// The path is four register stages: input, colour scores, best of each group
// of four, result. One item is taken every cycle when the receiver keeps up;
// the rate is set by the one-per-cycle advance of that stage chain.
// Reset empties all stages and clears the remap table to zeros, so an entry
// never loaded maps to index 0. When the receiver stalls, the result holds
// and the stages behind it fill; in_ch.ready drops only once all four hold
// an item. Loads and pixels pass the table at the same stage, so a pixel
// right behind a load of its entry sees the new value.
module icon_pixel_palette_remap_unit (
  input logic        clk,
  input logic        rst_n,
  pprm_in_if.sink    in_ch,
  pprm_out_if.source out_ch
);
  import pprm_pkg::*;

  // Stage 0: input register
  logic        s0_v_r;
  tag_t        s0_tag_r;
  logic [7:0]  s0_red_r;
  logic [7:0]  s0_green_r;
  logic [7:0]  s0_blue_r;

  // Stage 1: scores of all colours
  logic        s1_v_r;
  tag_t        s1_tag_r;
  score_t      s1_score_r [CGA_N];
  score_t      s0_score   [CGA_N];

  // Stage 2: best of each group
  logic        s2_v_r;
  tag_t        s2_tag_r;
  score_t      s2_score_r [GROUP_N];
  cga_idx_t    s2_idx_r   [GROUP_N];
  score_t      grp_score  [GROUP_N];
  cga_idx_t    grp_idx    [GROUP_N];

  // Result stage
  logic        out_v_r;
  logic [7:0]  code_r;
  logic [7:0]  code_nxt;
  score_t      fin_score;
  cga_idx_t    fin_idx;

  cga_idx_t    remap_r [CGA_N];

  logic rdy_out;
  logic rdy2;
  logic rdy1;
  logic rdy0;

  assign rdy_out = !out_v_r || out_ch.ready;
  assign rdy2    = !s2_v_r || rdy_out;
  assign rdy1    = !s1_v_r || rdy2;
  assign rdy0    = !s0_v_r || rdy1;

  assign in_ch.ready       = rdy0;
  assign out_ch.valid      = out_v_r;
  assign out_ch.pixel_code = code_r;

  pprm_dist u_dist (
    .red   (s0_red_r),
    .green (s0_green_r),
    .blue  (s0_blue_r),
    .score (s0_score)
  );

  for (genvar g = 0; g < GROUP_N; g++) begin : g_grp
    score_t   sc [4];
    cga_idx_t ix [4];
    for (genvar j = 0; j < 4; j++) begin : g_in
      assign sc[j] = s1_score_r[4*g+j];
      assign ix[j] = cga_idx_t'(4*g+j);
    end
    pprm_min4 u_min (
      .score      (sc),
      .idx        (ix),
      .best_score (grp_score[g]),
      .win_idx    (grp_idx[g])
    );
  end

  pprm_min4 u_final (
    .score      (s2_score_r),
    .idx        (s2_idx_r),
    .best_score (fin_score),
    .win_idx    (fin_idx)
  );

  always_comb begin
    if (s2_tag_r.opcode == OP_LOAD) begin
      code_nxt = {4'b0, fin_idx};
    end else if (s2_tag_r.mask_bit) begin
      code_nxt = TRANSPARENT_CODE;
    end else begin
      code_nxt = {4'b0, remap_r[s2_tag_r.color_index]};
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy0) begin
        s0_v_r <= in_ch.valid;
      end
      if (rdy1) begin
        s1_v_r <= s0_v_r;
      end
      if (rdy2) begin
        s2_v_r <= s1_v_r;
      end
      if (rdy_out) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (rdy0 && in_ch.valid) begin
      s0_tag_r.opcode      <= in_ch.opcode;
      s0_tag_r.entry_index <= in_ch.entry_index;
      s0_tag_r.color_index <= in_ch.color_index;
      s0_tag_r.mask_bit    <= in_ch.mask_bit;
      s0_red_r             <= in_ch.red;
      s0_green_r           <= in_ch.green;
      s0_blue_r            <= in_ch.blue;
    end
    if (rdy1 && s0_v_r) begin
      s1_tag_r   <= s0_tag_r;
      s1_score_r <= s0_score;
    end
    if (rdy2 && s1_v_r) begin
      s2_tag_r   <= s1_tag_r;
      s2_score_r <= grp_score;
      s2_idx_r   <= grp_idx;
    end
    if (rdy_out && s2_v_r) begin
      code_r <= code_nxt;
    end
  end

  // The table is written as a load moves into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < CGA_N; k++) begin
        remap_r[k] <= '0;
      end
    end else if (rdy_out && s2_v_r && (s2_tag_r.opcode == OP_LOAD)) begin
      remap_r[s2_tag_r.entry_index] <= fin_idx;
    end
  end

endmodule

/* src/pprm_checker.sv */
`timescale 1ns / 1ps

module pprm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] pixel_code
);

  // A stalled result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A stalled result keeps its value.
  a_code_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(pixel_code))
    else $error("result changed while stalled");

  // The block comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result offered straight after reset");

  // Input back-pressure only appears when the receiver is stalling a result.
  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a stalled result");

endmodule

bind icon_pixel_palette_remap_unit pprm_checker u_pprm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .pixel_code (out_ch.pixel_code)
);
